// ===== rtl/core/twwm_pkg.sv =====
`default_nettype none

package twwm_pkg;

    // Window geometry and field widths.
    localparam int unsigned NUM_PIX   = 9;
    localparam int unsigned NUM_ROWS  = 3;
    localparam int unsigned ROW_LEN   = 3;
    localparam int unsigned PIX_W     = 8;

    // Weights in half units: 4, 3 and 2 stand for 2.0, 1.5 and 1.0.
    localparam int unsigned WGT_W     = 3;
    localparam logic [WGT_W-1:0] WGT_NONE = 3'd0;
    localparam logic [WGT_W-1:0] WGT_LOW  = 3'd2;
    localparam logic [WGT_W-1:0] WGT_MID  = 3'd3;
    localparam logic [WGT_W-1:0] WGT_HIGH = 3'd4;

    // Tone bands.
    localparam logic [PIX_W-1:0] TONE_DARK_HI   = 8'd50;
    localparam logic [PIX_W-1:0] TONE_SHADE_LO  = 8'd51;
    localparam logic [PIX_W-1:0] TONE_SHADE_HI  = 8'd75;
    localparam logic [PIX_W-1:0] TONE_TINT_LO   = 8'd175;
    localparam logic [PIX_W-1:0] TONE_TINT_HI   = 8'd199;
    localparam logic [PIX_W-1:0] TONE_LIGHT_LO  = 8'd200;
    localparam logic [PIX_W-1:0] TONE_LIGHT_HI  = 8'd250;

    // One weighted pixel is at most 4*255, a row sum at most 3*1020,
    // the window sum at most 9180 and the weight total at most 36.
    localparam int unsigned PROD_W    = 10;
    localparam int unsigned ROW_SUM_W = 12;
    localparam int unsigned ROW_WGT_W = 4;
    localparam int unsigned ACC_W     = 14;
    localparam int unsigned TOT_W     = 6;

    // Divider: two quotient bits per stage.
    localparam int unsigned QUO_W       = 8;
    localparam int unsigned BITS_PER_ST = 2;
    localparam int unsigned NUM_DIV_ST  = QUO_W / BITS_PER_ST;

    typedef logic [NUM_PIX-1:0][PIX_W-1:0]        pix_arr_t;
    typedef logic [NUM_PIX-1:0][PROD_W-1:0]       prod_arr_t;
    typedef logic [NUM_PIX-1:0][WGT_W-1:0]        wgt_arr_t;
    typedef logic [NUM_ROWS-1:0][ROW_SUM_W-1:0]   row_sum_arr_t;
    typedef logic [NUM_ROWS-1:0][ROW_WGT_W-1:0]   row_wgt_arr_t;

    // Working set of one division in flight.
    typedef struct packed {
        logic [ACC_W-1:0] rem;
        logic [TOT_W-1:0] den;
        logic [QUO_W-1:0] quo;
        logic             zero;
    } div_t;

endpackage

`default_nettype wire

// ===== rtl/core/twwm_weigh.sv =====
`default_nettype none

module twwm_weigh
    import twwm_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire pix_arr_t            pix,
    input  wire logic [NUM_PIX-1:0]  mask,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output prod_arr_t                prod,
    output wgt_arr_t                 wgt
);

    // Weight of one tone in half units.
    function automatic logic [WGT_W-1:0] tone_weight(input logic [PIX_W-1:0] p);
        logic [WGT_W-1:0] w;
        if (p inside {[8'd0:TONE_DARK_HI], [TONE_LIGHT_LO:TONE_LIGHT_HI]}) begin
            w = WGT_HIGH;
        end
        else if (p inside {[TONE_SHADE_LO:TONE_SHADE_HI], [TONE_TINT_LO:TONE_TINT_HI]}) begin
            w = WGT_MID;
        end
        else begin
            w = WGT_LOW;
        end
        return w;
    endfunction

    logic      vld_reg;
    prod_arr_t prod_reg;
    prod_arr_t prod_next;
    wgt_arr_t  wgt_reg;
    wgt_arr_t  wgt_next;

    assign in_ready  = !vld_reg || out_ready;
    assign out_valid = vld_reg;
    assign prod      = prod_reg;
    assign wgt       = wgt_reg;

    // Each lane picks its weight and forms weight times pixel by shift and add.
    always_comb
    begin
        for (int k = 0; k < NUM_PIX; k++)
        begin
            wgt_next[k] = mask[k] ? tone_weight(pix[k]) : WGT_NONE;
            case (wgt_next[k])
                WGT_HIGH: prod_next[k] = {pix[k], 2'b00};
                WGT_MID:  prod_next[k] = {2'b00, pix[k]} + {1'b0, pix[k], 1'b0};
                WGT_LOW:  prod_next[k] = {1'b0, pix[k], 1'b0};
                default:  prod_next[k] = '0;
            endcase
        end
    end

    // Stage valid bit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            vld_reg <= 1'b0;
        end
        else if (in_ready) begin
            vld_reg <= in_valid;
        end
    end

    // Stage payload is loaded on every transfer into the stage.
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid) begin
            prod_reg <= prod_next;
            wgt_reg  <= wgt_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/twwm_sum.sv =====
`default_nettype none

module twwm_sum
    import twwm_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire prod_arr_t prod,
    input  wire wgt_arr_t  wgt,
    output logic           out_valid,
    input  wire logic      out_ready,
    output div_t           out_data
);

    logic         row_vld_reg;
    row_sum_arr_t row_sum_reg;
    row_sum_arr_t row_sum_next;
    row_wgt_arr_t row_wgt_reg;
    row_wgt_arr_t row_wgt_next;
    logic         row_ready;

    logic         tot_vld_reg;
    div_t         tot_reg;
    div_t         tot_next;

    logic [ACC_W-1:0] acc_sum;
    logic [TOT_W-1:0] wgt_sum;

    assign row_ready = !tot_vld_reg || out_ready;
    assign in_ready  = !row_vld_reg || row_ready;
    assign out_valid = tot_vld_reg;
    assign out_data  = tot_reg;

    // First stage: sum each window row on its own.
    always_comb
    begin
        for (int r = 0; r < NUM_ROWS; r++)
        begin
            row_sum_next[r] = ROW_SUM_W'(prod[ROW_LEN*r])
                            + ROW_SUM_W'(prod[ROW_LEN*r+1])
                            + ROW_SUM_W'(prod[ROW_LEN*r+2]);
            row_wgt_next[r] = ROW_WGT_W'(wgt[ROW_LEN*r])
                            + ROW_WGT_W'(wgt[ROW_LEN*r+1])
                            + ROW_WGT_W'(wgt[ROW_LEN*r+2]);
        end
    end

    // Second stage: combine the rows and set up the division.
    always_comb
    begin
        acc_sum = ACC_W'(row_sum_reg[0]) + ACC_W'(row_sum_reg[1])
                + ACC_W'(row_sum_reg[2]);
        wgt_sum = TOT_W'(row_wgt_reg[0]) + TOT_W'(row_wgt_reg[1])
                + TOT_W'(row_wgt_reg[2]);
        tot_next.rem  = acc_sum;
        tot_next.den  = wgt_sum;
        tot_next.quo  = '0;
        tot_next.zero = (wgt_sum == '0);
    end

    // Stage valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            row_vld_reg <= 1'b0;
            tot_vld_reg <= 1'b0;
        end
        else begin
            if (in_ready) begin
                row_vld_reg <= in_valid;
            end
            if (row_ready) begin
                tot_vld_reg <= row_vld_reg;
            end
        end
    end

    // Stage payloads.
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid) begin
            row_sum_reg <= row_sum_next;
            row_wgt_reg <= row_wgt_next;
        end
        if (row_ready && row_vld_reg) begin
            tot_reg <= tot_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/twwm_div.sv =====
`default_nettype none

module twwm_div
    import twwm_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire div_t       in_data,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [QUO_W-1:0] quotient
);

    localparam int unsigned LAST = NUM_DIV_ST - 1;

    // Two restoring steps, quotient bits hi and hi-1. The mean never
    // exceeds 255, so the dividend is always below den * 256.
    function automatic div_t div_step2(input div_t d, input int unsigned hi);
        div_t           r;
        logic [ACC_W:0] sub;
        r = d;
        for (int k = 0; k < BITS_PER_ST; k++)
        begin
            sub = (ACC_W+1)'(r.den) << (hi - k);
            if ({1'b0, r.rem} >= sub) begin
                r.rem         = r.rem - sub[ACC_W-1:0];
                r.quo[hi - k] = 1'b1;
            end
        end
        return r;
    endfunction

    logic [NUM_DIV_ST-1:0] vld_reg;
    logic [NUM_DIV_ST-1:0] rdy;
    div_t                  dat_reg  [NUM_DIV_ST];
    div_t                  dat_next [NUM_DIV_ST];

    assign in_ready  = rdy[0];
    assign out_valid = vld_reg[LAST];
    assign quotient  = dat_reg[LAST].zero ? '0 : dat_reg[LAST].quo;

    // A stage can load when it is empty or its content moves on.
    always_comb
    begin
        rdy[LAST] = !vld_reg[LAST] || out_ready;
        for (int s = LAST - 1; s >= 0; s--)
        begin
            rdy[s] = !vld_reg[s] || rdy[s+1];
        end
    end

    // Each stage resolves the next two quotient bits, most significant first.
    always_comb
    begin
        dat_next[0] = div_step2(in_data, QUO_W - 1);
        for (int s = 1; s < NUM_DIV_ST; s++)
        begin
            dat_next[s] = div_step2(dat_reg[s-1], QUO_W - 1 - BITS_PER_ST * s);
        end
    end

    // Stage valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            vld_reg <= '0;
        end
        else begin
            if (rdy[0]) begin
                vld_reg[0] <= in_valid;
            end
            for (int s = 1; s < NUM_DIV_ST; s++)
            begin
                if (rdy[s]) begin
                    vld_reg[s] <= vld_reg[s-1];
                end
            end
        end
    end

    // Stage payloads.
    always_ff @(posedge clk)
    begin
        if (rdy[0] && in_valid) begin
            dat_reg[0] <= dat_next[0];
        end
        for (int s = 1; s < NUM_DIV_ST; s++)
        begin
            if (rdy[s] && vld_reg[s-1]) begin
                dat_reg[s] <= dat_next[s];
            end
        end
    end

    // The dividend entering the divider must give a quotient that fits.
    a_div_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && rdy[0] && !in_data.zero |->
            (ACC_W+QUO_W)'(in_data.rem) < ((ACC_W+QUO_W)'(in_data.den) << QUO_W))
        else $error("divider input quotient exceeds eight bits");

    // After the last step the remainder lies below the divisor.
    a_div_rem_done: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[LAST] && !dat_reg[LAST].zero |->
            dat_reg[LAST].rem < ACC_W'(dat_reg[LAST].den))
        else $error("divider remainder not reduced below divisor");

    // An empty window carries a zero weighted sum.
    a_div_empty: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[LAST] && dat_reg[LAST].zero |-> dat_reg[LAST].rem == '0)
        else $error("empty window with nonzero weighted sum");

endmodule

`default_nettype wire

// ===== rtl/core/tonal_weighted_window_mean.sv =====
// Tone-weighted mean of one 3x3 pixel window.
//
// Input channel: in_valid / in_stall with the nine window pixels pix_00..pix_22
// and window_valid, whose bit 3*r+c marks that position r,c lies inside the
// image. Only marked pixels count. Output channel: out_valid / out_stall with
// weighted_mean, the floor of the tone-weighted sum over the weight total, or
// 0 for an empty mask. A transfer happens on a clock edge with valid high and
// stall low.
//
// There are seven register stages: one for the tone weights, two for the
// adder tree and four for the divider, which resolves two quotient bits per
// stage. Throughput is one window per cycle while out_stall stays low.
//
// Reset (rst_n low, asynchronous) empties the pipeline; no other state exists.
// When the receiver stalls, the output holds and the stages behind it keep
// filling any empty slots, so in_stall rises only once every stage is full.
// Nothing is dropped or repeated.
`default_nettype none

module tonal_weighted_window_mean
    import twwm_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_stall,
    input  wire logic [PIX_W-1:0] pix_00,
    input  wire logic [PIX_W-1:0] pix_01,
    input  wire logic [PIX_W-1:0] pix_02,
    input  wire logic [PIX_W-1:0] pix_10,
    input  wire logic [PIX_W-1:0] pix_11,
    input  wire logic [PIX_W-1:0] pix_12,
    input  wire logic [PIX_W-1:0] pix_20,
    input  wire logic [PIX_W-1:0] pix_21,
    input  wire logic [PIX_W-1:0] pix_22,
    input  wire logic [NUM_PIX-1:0] window_valid,
    output logic                  out_valid,
    input  wire logic             out_stall,
    output logic [QUO_W-1:0]      weighted_mean
);

    pix_arr_t  pix;
    logic      weigh_ready;
    logic      weigh_valid;
    prod_arr_t weigh_prod;
    wgt_arr_t  weigh_wgt;
    logic      sum_ready;
    logic      sum_valid;
    div_t      sum_data;
    logic      div_ready;

    // Gather the window in row-major order.
    assign pix = {pix_22, pix_21, pix_20, pix_12, pix_11, pix_10,
                  pix_02, pix_01, pix_00};

    assign in_stall = !weigh_ready;

    // Tone weights and weighted pixels.
    twwm_weigh u_weigh (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (weigh_ready),
        .pix       (pix),
        .mask      (window_valid),
        .out_valid (weigh_valid),
        .out_ready (sum_ready),
        .prod      (weigh_prod),
        .wgt       (weigh_wgt)
    );

    // Adder tree for the weighted sum and the weight total.
    twwm_sum u_sum (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (weigh_valid),
        .in_ready  (sum_ready),
        .prod      (weigh_prod),
        .wgt       (weigh_wgt),
        .out_valid (sum_valid),
        .out_ready (div_ready),
        .out_data  (sum_data)
    );

    // Pipelined divider; its last stage is the output register.
    twwm_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sum_valid),
        .in_ready  (div_ready),
        .in_data   (sum_data),
        .out_valid (out_valid),
        .out_ready (!out_stall),
        .quotient  (weighted_mean)
    );

endmodule

`default_nettype wire

// ===== tb/tonal_weighted_window_mean_tb.sv =====
module tonal_weighted_window_mean_tb;
    import twwm_pkg::*;

    localparam int CLK_HALF       = 10;
    localparam int RANDOM_WINDOWS = 1600;
    localparam int PHASE_LEN      = 200;
    localparam int DRAIN_CYCLES   = 30;
    localparam int CYCLE_LIMIT    = 200000;

    // Pixel values that sit on or next to the tone band limits.
    localparam logic [PIX_W-1:0] TONE_LIMITS [12] =
        '{8'd0, 8'd50, 8'd51, 8'd75, 8'd76, 8'd174,
          8'd175, 8'd199, 8'd200, 8'd250, 8'd251, 8'd255};

    // Predicts the tone-weighted mean of each accepted window and checks
    // every output transfer against the oldest prediction.
    class mean_scoreboard;
        logic [QUO_W-1:0] expected_means [$];
        int errors;

        function new();
            errors = 0;
        endfunction

        // Weight of one pixel in half units.
        function int unsigned tone_weight(logic [PIX_W-1:0] tone);
            if (tone <= TONE_DARK_HI || (tone >= TONE_LIGHT_LO && tone <= TONE_LIGHT_HI))
                return 32'(WGT_HIGH);
            if ((tone >= TONE_SHADE_LO && tone <= TONE_SHADE_HI) ||
                (tone >= TONE_TINT_LO && tone <= TONE_TINT_HI))
                return 32'(WGT_MID);
            return 32'(WGT_LOW);
        endfunction

        function void note_window(pix_arr_t win, logic [NUM_PIX-1:0] mask);
            int unsigned acc;
            int unsigned total;
            int unsigned w;
            logic [QUO_W-1:0] mean;
            acc   = 0;
            total = 0;
            for (int k = 0; k < NUM_PIX; k++)
            begin
                if (mask[k])
                begin
                    w     = tone_weight(win[k]);
                    acc   += w * win[k];
                    total += w;
                end
            end
            // An empty mask yields zero; otherwise the quotient is floored.
            mean = (total == 0) ? '0 : QUO_W'(acc / total);
            expected_means = {expected_means, mean};
        endfunction

        function void check_mean(logic [QUO_W-1:0] got);
            logic [QUO_W-1:0] want;
            if (expected_means.size() == 0)
            begin
                $display("%0t: weighted_mean transfer with none pending: expected none, actual %0d",
                         $time, got);
                errors++;
            end
            else
            begin
                want = expected_means.pop_front();
                if (got !== want)
                begin
                    $display("%0t: weighted_mean: expected %0d, actual %0d", $time, want, got);
                    errors++;
                end
            end
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    logic [PIX_W-1:0]     pix_00, pix_01, pix_02;
    logic [PIX_W-1:0]     pix_10, pix_11, pix_12;
    logic [PIX_W-1:0]     pix_20, pix_21, pix_22;
    logic [NUM_PIX-1:0]   window_valid;
    logic                 out_valid;
    logic                 out_stall;
    logic [QUO_W-1:0]     weighted_mean;

    mean_scoreboard sb;
    bit             quiet;
    int             stall_left;
    int             cycle_count;

    tonal_weighted_window_mean u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .pix_00        (pix_00),
        .pix_01        (pix_01),
        .pix_02        (pix_02),
        .pix_10        (pix_10),
        .pix_11        (pix_11),
        .pix_12        (pix_12),
        .pix_20        (pix_20),
        .pix_21        (pix_21),
        .pix_22        (pix_22),
        .window_valid  (window_valid),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .weighted_mean (weighted_mean)
    );

    // Clock.
    initial clk = 1'b0;
    always #CLK_HALF clk = ~clk;

    // Number of idle cycles before a transfer; zero during quiet phases.
    function automatic int idle_draw();
        return quiet ? 0 : $urandom_range(0, 5);
    endfunction

    // Random tone, often placed on a band limit.
    function automatic logic [PIX_W-1:0] draw_tone();
        if ($urandom_range(0, 9) < 3)
            return TONE_LIMITS[$urandom_range(0, 11)];
        return PIX_W'($urandom_range(0, 255));
    endfunction

    // Full windows half the time, some empty ones, the rest with random masks.
    function automatic logic [NUM_PIX-1:0] draw_mask();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 5)
            return '1;
        if (pick == 5)
            return '0;
        return NUM_PIX'($urandom_range(0, 511));
    endfunction

    // Presents one window after a random gap and holds it until transfer.
    task automatic send_window(input pix_arr_t win, input logic [NUM_PIX-1:0] mask);
        int gap;
        gap = idle_draw();
        repeat (gap)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid     <= 1'b1;
        pix_00       <= win[0];
        pix_01       <= win[1];
        pix_02       <= win[2];
        pix_10       <= win[3];
        pix_11       <= win[4];
        pix_12       <= win[5];
        pix_20       <= win[6];
        pix_21       <= win[7];
        pix_22       <= win[8];
        window_valid <= mask;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // Stops sending and waits until every expected result has come.
    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.expected_means.size() != 0)
            @(posedge clk);
    endtask

    // Watch both channels at the rising edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                sb.note_window({pix_22, pix_21, pix_20, pix_12, pix_11, pix_10,
                                pix_02, pix_01, pix_00}, window_valid);
            if (out_valid && !out_stall)
            begin
                sb.check_mean(weighted_mean);
                stall_left = idle_draw();
            end
        end
    end

    // Receiver stalls for the drawn number of cycles before each result.
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left--;
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tonal_weighted_window_mean: mismatch");
            $finish;
        end
    end

    // Stimulus and end of run.
    initial
    begin
        pix_arr_t win;
        sb           = new();
        quiet        = 1'b0;
        stall_left   = 0;
        cycle_count  = 0;
        rst_n        <= 1'b0;
        in_valid     <= 1'b0;
        out_stall    <= 1'b0;
        pix_00       <= '0;
        pix_01       <= '0;
        pix_02       <= '0;
        pix_10       <= '0;
        pix_11       <= '0;
        pix_12       <= '0;
        pix_20       <= '0;
        pix_21       <= '0;
        pix_22       <= '0;
        window_valid <= '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // All black and all white windows.
        send_window('0, '1);
        send_window('1, '1);

        // Empty mask gives zero whatever the pixels.
        for (int k = 0; k < NUM_PIX; k++)
            win[k] = draw_tone();
        send_window(win, '0);

        // Full windows across the band limits, including tones above 250.
        for (int k = 0; k < NUM_PIX; k++)
            win[k] = TONE_LIMITS[k + 1];
        send_window(win, '1);
        win = {8'd125, 8'd49, 8'd1, 8'd0, 8'd255, 8'd254, 8'd253, 8'd252, 8'd251};
        send_window(win, '1);

        // A single marked position returns that pixel.
        for (int k = 0; k < NUM_PIX; k++)
        begin
            for (int j = 0; j < NUM_PIX; j++)
                win[j] = draw_tone();
            win[k] = TONE_LIMITS[k + 2];
            send_window(win, NUM_PIX'(1 << k));
        end

        // Windows with one position off the image.
        for (int k = 0; k < NUM_PIX; k += 4)
        begin
            for (int j = 0; j < NUM_PIX; j++)
                win[j] = draw_tone();
            send_window(win, ~NUM_PIX'(1 << k));
        end

        // Random windows in phases, alternating between idling and none.
        for (int i = 0; i < RANDOM_WINDOWS; i++)
        begin
            if (i % PHASE_LEN == 0)
                quiet = ((i / PHASE_LEN) % 2) == 1;
            if (i == RANDOM_WINDOWS / 2)
                wait_drained();
            for (int j = 0; j < NUM_PIX; j++)
                win[j] = draw_tone();
            send_window(win, draw_mask());
        end
        @(negedge clk);
        in_valid <= 1'b0;

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0)
            $display("tonal_weighted_window_mean: match");
        else
            $display("tonal_weighted_window_mean: mismatch");
        $finish;
    end

endmodule
